FILE: rtl/core/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// shared types, constants and helper functions of the quaternion to euler unit
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int W_Q    = 16;
    localparam int W_PROD = 32;
    localparam int W_TERM = 36;
    localparam int W_T2   = 30;
    localparam int W_RAD  = 57;
    localparam int W_ROOT = 58;
    localparam int W_S    = 29;
    localparam int W_CORD = 38;
    localparam int W_ANG  = 25;
    localparam int W_RND  = 18;
    localparam int W_OUT  = 16;
    localparam int W_PIT  = 15;

    localparam int N_ROOT = 29;
    localparam int N_ITER = 20;
    localparam int N_CORD = N_ITER + 1;
    localparam int N_BACK = N_ROOT + N_CORD + 1;

    localparam logic signed [W_TERM-1:0] ONE_Q28     = W_TERM'(64'sd1 <<< 28);
    localparam logic signed [W_TERM-1:0] NEG_ONE_Q28 = -ONE_Q28;
    localparam logic [W_ROOT-1:0]        ONE_Q56     = W_ROOT'(64'd1 << 56);
    localparam logic signed [W_ANG-1:0]  HALF_PI_Q20 = W_ANG'(1647099);
    localparam logic signed [W_ANG-1:0]  RND_Q20     = W_ANG'(64);
    localparam logic signed [W_OUT-1:0]  PI_Q13      = W_OUT'(25736);
    localparam logic signed [W_OUT-1:0]  HALF_PI_Q13 = W_OUT'(12868);

    typedef struct packed {
        logic signed [W_TERM-1:0] t0;
        logic signed [W_TERM-1:0] t1;
        logic signed [W_T2-1:0]   t2;
        logic signed [W_TERM-1:0] t3;
        logic signed [W_TERM-1:0] t4;
        logic [W_RAD-1:0]         rad;
    } t_front_item;

    function automatic logic [19:0] atan_q20(input int unsigned idx);
        logic [19:0] r;
        case (idx)
            0:       r = 20'd823550;
            1:       r = 20'd486170;
            2:       r = 20'd256879;
            3:       r = 20'd130396;
            4:       r = 20'd65451;
            5:       r = 20'd32757;
            6:       r = 20'd16383;
            7:       r = 20'd8192;
            8:       r = 20'd4096;
            9:       r = 20'd2048;
            10:      r = 20'd1024;
            11:      r = 20'd512;
            12:      r = 20'd256;
            13:      r = 20'd128;
            14:      r = 20'd64;
            15:      r = 20'd32;
            16:      r = 20'd16;
            17:      r = 20'd8;
            18:      r = 20'd4;
            19:      r = 20'd2;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [W_OUT-1:0] sat_angle(
        input logic signed [W_RND-1:0] a,
        input logic signed [W_OUT-1:0] lim
    );
        logic signed [W_RND-1:0] l;
        logic signed [W_OUT-1:0] r;
        l = W_RND'(lim);
        if (a > l) begin
            r = lim;
        end else if (a < -l) begin
            r = -lim;
        end else begin
            r = a[W_OUT-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// input side: component products, angle terms, pitch term saturation and
// radicand for the pitch square root
// ----------------------------------------------------------------------------
module q2e_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
    input  logic                  i_full,
    output logic                  o_push,
    output q2e_pkg::t_front_item  o_item
);

    localparam int WP = q2e_pkg::W_PROD;
    localparam int WT = q2e_pkg::W_TERM;

    logic signed [q2e_pkg::W_Q-1:0] qx, qy, qz, qw;
    logic signed [WP-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic signed [WT-1:0] r_t0, r_t1, r_t3, r_t4;
    logic signed [q2e_pkg::W_T2-1:0] r_t2;
    logic signed [WT-1:0] n_t2raw;
    logic signed [q2e_pkg::W_T2-1:0] n_t2;
    logic signed [2*q2e_pkg::W_T2-1:0] sq;
    q2e_pkg::t_front_item r_item;
    logic r_vld0, r_vld1, r_vld2;
    logic rdy0, rdy1, rdy2;

    assign qx = $signed(s_axis_tdata[15:0]);
    assign qy = $signed(s_axis_tdata[31:16]);
    assign qz = $signed(s_axis_tdata[47:32]);
    assign qw = $signed(s_axis_tdata[63:48]);

    assign rdy2 = !r_vld2 || !i_full;
    assign rdy1 = !r_vld1 || rdy2;
    assign rdy0 = !r_vld0 || rdy1;
    assign s_axis_tready = rdy0;
    assign o_push = r_vld2 && !i_full;
    assign o_item = r_item;

    always_comb begin
        n_t2raw = (WT'(r_wy) - WT'(r_zx)) <<< 1;
        if (n_t2raw > q2e_pkg::ONE_Q28) begin
            n_t2 = q2e_pkg::W_T2'(q2e_pkg::ONE_Q28);
        end else if (n_t2raw < q2e_pkg::NEG_ONE_Q28) begin
            n_t2 = q2e_pkg::W_T2'(q2e_pkg::NEG_ONE_Q28);
        end else begin
            n_t2 = n_t2raw[q2e_pkg::W_T2-1:0];
        end
        sq = r_t2 * r_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_vld0 <= s_axis_tvalid;
            end
            if (rdy1) begin
                r_vld1 <= r_vld0;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_wx <= qw * qx;
            r_yz <= qy * qz;
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_wy <= qw * qy;
            r_zx <= qz * qx;
            r_wz <= qw * qz;
            r_xy <= qx * qy;
            r_zz <= qz * qz;
        end
        if (rdy1) begin
            r_t0 <= (WT'(r_wx) + WT'(r_yz)) <<< 1;
            r_t1 <= q2e_pkg::ONE_Q28 - ((WT'(r_xx) + WT'(r_yy)) <<< 1);
            r_t2 <= n_t2;
            r_t3 <= (WT'(r_wz) + WT'(r_xy)) <<< 1;
            r_t4 <= q2e_pkg::ONE_Q28 - ((WT'(r_yy) + WT'(r_zz)) <<< 1);
        end
        if (rdy2) begin
            r_item.t0  <= r_t0;
            r_item.t1  <= r_t1;
            r_item.t2  <= r_t2;
            r_item.t3  <= r_t3;
            r_item.t4  <= r_t4;
            r_item.rad <= q2e_pkg::W_RAD'(q2e_pkg::ONE_Q56 - sq[q2e_pkg::W_ROOT-1:0]);
        end
    end

endmodule

FILE: rtl/core/q2e_fifo.sv
// ----------------------------------------------------------------------------
// q2e_fifo
// short register queue between the front and back halves
// ----------------------------------------------------------------------------
module q2e_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  q2e_pkg::t_front_item  i_item,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output q2e_pkg::t_front_item  o_item
);

    localparam int WA = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WC = $clog2(DEPTH + 1);

    q2e_pkg::t_front_item r_mem [0:DEPTH-1];
    logic [WA-1:0] r_wr, r_rd;
    logic [WC-1:0] r_cnt;

    assign o_full  = (r_cnt == WC'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == WA'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == WA'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/q2e_sqrt.sv
// ----------------------------------------------------------------------------
// q2e_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module q2e_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [q2e_pkg::W_RAD-1:0]     i_rad,
    output logic [q2e_pkg::W_S-1:0]       o_root
);

    localparam int N  = q2e_pkg::N_ROOT;
    localparam int WR = q2e_pkg::W_ROOT;

    logic [WR-1:0] r_v   [0:N-1];
    logic [WR-1:0] r_res [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [WR-1:0] BIT = WR'(1) << (2 * (N - 1 - k));
        logic [WR-1:0] v_in, res_in, sum;

        if (k == 0) begin : g_first
            assign v_in   = WR'(i_rad);
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign res_in = r_res[k-1];
        end

        assign sum = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_in >= sum) begin
                    r_v[k]   <= v_in - sum;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_v[k]   <= v_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[N-1][q2e_pkg::W_S-1:0];

endmodule

FILE: rtl/core/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic for atan2, quadrant stage then one stage per step
// ----------------------------------------------------------------------------
module q2e_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [q2e_pkg::W_CORD-1:0]   i_num,
    input  logic signed [q2e_pkg::W_CORD-1:0]   i_den,
    output logic signed [q2e_pkg::W_RND-1:0]    o_angle
);

    localparam int N  = q2e_pkg::N_ITER;
    localparam int WC = q2e_pkg::W_CORD;
    localparam int WZ = q2e_pkg::W_ANG;

    logic signed [WC-1:0] r_x [0:N];
    logic signed [WC-1:0] r_y [0:N];
    logic signed [WZ-1:0] r_z [0:N];
    logic                 r_zero [0:N];
    logic signed [WZ-1:0] zr;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_num == '0) && (i_den == '0);
            if (i_den < 0) begin
                if (i_num >= 0) begin
                    r_x[0] <= i_num;
                    r_y[0] <= -i_den;
                    r_z[0] <= q2e_pkg::HALF_PI_Q20;
                end else begin
                    r_x[0] <= -i_num;
                    r_y[0] <= i_den;
                    r_z[0] <= -q2e_pkg::HALF_PI_Q20;
                end
            end else begin
                r_x[0] <= i_den;
                r_y[0] <= i_num;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic signed [WZ-1:0] ATN = WZ'(q2e_pkg::atan_q20(i));
        logic signed [WC-1:0] xs, ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ATN;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ATN;
                end
            end
        end
    end

    assign zr      = (r_z[N] + q2e_pkg::RND_Q20) >>> 7;
    assign o_angle = r_zero[N] ? '0 : zr[q2e_pkg::W_RND-1:0];

endmodule

FILE: rtl/core/q2e_back.sv
// ----------------------------------------------------------------------------
// q2e_back
// execution side: pitch square root and three atan2 pipelines, saturation,
// alignment of the three angles and the output register
// ----------------------------------------------------------------------------
module q2e_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  q2e_pkg::t_front_item  i_item,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata  // yaw_angle, pitch_angle, roll_angle
);

    localparam int WC = q2e_pkg::W_CORD;
    localparam int WO = q2e_pkg::W_OUT;
    localparam int ND = q2e_pkg::N_ROOT + 1;
    localparam int NB = q2e_pkg::N_BACK;

    logic en;
    logic [NB-1:0] r_vld;
    logic [q2e_pkg::W_S-1:0] root;
    logic signed [q2e_pkg::W_RND-1:0] roll_a, pitch_a, yaw_a;
    logic signed [WO-1:0] r_roll  [0:ND-1];
    logic signed [WO-1:0] r_yaw   [0:ND-1];
    logic signed [WO-1:0] r_pitch;
    logic signed [WO-1:0] pitch_s;

    assign en    = !r_vld[NB-1] || m_axis_tready;
    assign o_pop = en && !i_empty;

    q2e_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (WC'(i_item.t0)),
        .i_den   (WC'(i_item.t1)),
        .o_angle (roll_a)
    );

    q2e_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (WC'(i_item.t3)),
        .i_den   (WC'(i_item.t4)),
        .o_angle (yaw_a)
    );

    q2e_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (i_item.rad),
        .o_root (root)
    );

    logic signed [q2e_pkg::W_T2-1:0] r_t2_d [0:q2e_pkg::N_ROOT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2_d[0] <= i_item.t2;
            for (int k = 1; k < q2e_pkg::N_ROOT; k++) begin
                r_t2_d[k] <= r_t2_d[k-1];
            end
        end
    end

    q2e_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num   (WC'(r_t2_d[q2e_pkg::N_ROOT-1])),
        .i_den   (WC'({1'b0, root})),
        .o_angle (pitch_a)
    );

    assign pitch_s = q2e_pkg::sat_angle(pitch_a, q2e_pkg::HALF_PI_Q13);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll[0] <= q2e_pkg::sat_angle(roll_a, q2e_pkg::PI_Q13);
            r_yaw[0]  <= q2e_pkg::sat_angle(yaw_a, q2e_pkg::PI_Q13);
            for (int k = 1; k < ND; k++) begin
                r_roll[k] <= r_roll[k-1];
                r_yaw[k]  <= r_yaw[k-1];
            end
            r_pitch <= pitch_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NB-2:0], !i_empty};
        end
    end

    assign m_axis_tvalid = r_vld[NB-1];
    assign m_axis_tdata  = {1'b0, r_roll[ND-1], r_pitch[q2e_pkg::W_PIT-1:0], r_yaw[ND-1]};

endmodule

FILE: rtl/core/quaternion_to_euler_angles_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// unit quaternion (Q1.14) to z-y-x euler angles roll, pitch, yaw (Q3.13 rad)
// ----------------------------------------------------------------------------
// Accepts one quaternion per clock and returns one set of angles per clock
// when the output side keeps up. An input transfer passes through the
// product and term pipeline, the queue, and the back end: a 29-stage square
// root feeding a 21-stage atan2 cordic for pitch, with roll and yaw cordics
// running alongside and delayed to match. The front and back halves stall
// separately through the queue between them; while a result waits, the queue
// and the front registers let new quaternions in until they are full.
module quaternion_to_euler_angles_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // yaw_angle, pitch_angle, roll_angle, pad
);

    q2e_pkg::t_front_item front_item, queue_item;
    logic push, pop, full, empty;

    q2e_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (full),
        .o_push        (push),
        .o_item        (front_item)
    );

    q2e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    q2e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: rtl/core/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker
// port-level checks of the quaternion to euler unit, bound to the top level
// ----------------------------------------------------------------------------
module q2e_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    localparam logic signed [15:0] PI_LIM   = 16'sd25736;
    localparam logic signed [14:0] HALF_LIM = 15'sd12868;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= PI_LIM &&
                           $signed(m_axis_tdata[15:0]) >= -PI_LIM))
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= HALF_LIM &&
                           $signed(m_axis_tdata[30:16]) >= -HALF_LIM))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[46:31]) <= PI_LIM &&
                           $signed(m_axis_tdata[46:31]) >= -PI_LIM &&
                           !m_axis_tdata[47]))
        else $error("roll out of range or pad set");

    a_in_first: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (.*);
